/* sv/arbs_pkg.sv */
// ----------------------------------------------------------------------------
// arbs_pkg
// Shared types and constants of the aged request buffer.
// ----------------------------------------------------------------------------
package arbs_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam longint unsigned MAX_AGE_DEF = 64'd65536;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_ALLOC  = 3'd1;
  localparam logic [2:0] ACT_SET    = 3'd2;
  localparam logic [2:0] ACT_OLDEST = 3'd3;
  localparam logic [2:0] ACT_ADDR   = 3'd4;
  localparam logic [2:0] ACT_AGE    = 3'd5;

  localparam logic [2:0] ST_FREE = 3'd0;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  idx;
    logic [2:0]  status;
    logic [63:0] now;
    logic [63:0] limit;
    logic [63:0] ready_at;
    logic [63:0] addr;
    logic        ans;
    logic        set_hit;
  } arbs_cmd_t;

  // Running scan result carried from cell to cell.
  typedef struct packed {
    logic        done;
    logic        found;
    logic [7:0]  pos;
    logic [63:0] best_rq;
    logic        found_ans;
    logic [7:0]  ans_pos;
    logic [63:0] best_an;
    logic        age_ok;
    logic [31:0] max_age;
  } arbs_scan_t;

endpackage

/* sv/arbs_cell.sv */
// ----------------------------------------------------------------------------
// arbs_cell
// One table entry: holds its fields, updates the scan token as it passes.
// ----------------------------------------------------------------------------
module arbs_cell
  import arbs_pkg::*;
#(
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             act_i,
  input  logic [IDX_W-1:0] my_idx_i,
  input  logic             set_sel_i,
  input  arbs_cmd_t        cmd_i,
  input  arbs_scan_t       scan_i,
  output arbs_scan_t       scan_o
);

  logic [2:0]  status_q;
  logic [63:0] ready_q, birth_q, addr_q;
  logic        ans_q;
  logic        rdy, take, ch;
  logic [63:0] age;
  arbs_scan_t  s;

  assign rdy  = (status_q == cmd_i.status) && (ready_q <= cmd_i.now);
  assign take = act_i && !scan_i.done && (cmd_i.action == ACT_ALLOC) && (status_q == ST_FREE);
  assign ch   = act_i && (cmd_i.action == ACT_SET) && set_sel_i;
  assign age  = cmd_i.now - birth_q;

  always_comb begin
    s = scan_i;
    if (act_i) begin
      case (cmd_i.action)
        ACT_ALLOC: begin
          if (take) begin
            s.done = 1'b1; s.found = 1'b1; s.pos = 8'(my_idx_i);
          end
        end
        ACT_OLDEST: begin
          if (rdy) begin
            if (ans_q) begin
              if (!s.found_ans || birth_q < s.best_an) begin
                s.found_ans = 1'b1; s.ans_pos = 8'(my_idx_i); s.best_an = birth_q;
              end
            end else if (!s.found || birth_q < s.best_rq) begin
              s.found = 1'b1; s.pos = 8'(my_idx_i); s.best_rq = birth_q;
            end
          end
        end
        ACT_ADDR: begin
          if (!s.done && rdy && addr_q == cmd_i.addr) begin
            s.done = 1'b1; s.found = 1'b1; s.pos = 8'(my_idx_i);
          end
        end
        ACT_AGE: begin
          if (!s.done && status_q != ST_FREE) begin
            if (birth_q < cmd_i.limit) begin
              s.done = 1'b1; s.age_ok = 1'b0;
            end else if (age > {32'd0, s.max_age}) begin
              s.max_age = (age[63:32] != 32'd0) ? 32'hFFFF_FFFF : age[31:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_o   <= '0;
      status_q <= ST_FREE;
    end else begin
      scan_o <= s;
      if (take) begin
        status_q <= cmd_i.status;
      end else if (ch) begin
        status_q <= cmd_i.status;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ready_q <= cmd_i.ready_at;
      birth_q <= cmd_i.now;
      addr_q  <= cmd_i.addr;
      ans_q   <= cmd_i.ans;
    end else if (ch) begin
      if (cmd_i.status == ST_FREE) begin
        ready_q <= cmd_i.now;
        birth_q <= cmd_i.now;
        addr_q  <= '0;
        ans_q   <= 1'b0;
      end else begin
        ready_q <= cmd_i.ready_at;
      end
    end
  end

endmodule

/* sv/aged_request_buffer_select.sv */
// ----------------------------------------------------------------------------
// aged_request_buffer_select
// Request table with oldest-ready-first pick, address lookup and age check.
//
//   channel  | ports                                              | flow
//   request  | start, busy_o, action_i .. answer_flag_i           | start & !busy_o
//   result   | done_o, found_o .. oldest_age_o                    | one-cycle strobe
//
// Each request walks the row of ENTRIES cells, one cell a cycle; done_o
// rises when the walk ends and busy_o drops with it, so the next request
// can be taken while done_o is high, never before the last one is through.
// Reset empties the table and clears the cycle counter and the largest age.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module aged_request_buffer_select
  import arbs_pkg::*;
#(
  parameter int unsigned     ENTRIES = ENTRIES_DEF,
  parameter longint unsigned MAX_AGE = MAX_AGE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy_o,
  input  logic [2:0]  action_i,
  input  logic [3:0]  entry_index_i,
  input  logic [2:0]  entry_status_i,
  input  logic [15:0] stall_time_i,
  input  logic [63:0] req_address_i,
  input  logic        answer_flag_i,
  output logic        done_o,
  output logic        found_o,
  output logic [3:0]  position_o,
  output logic        found_answer_o,
  output logic [3:0]  answer_position_o,
  output logic        age_ok_o,
  output logic [31:0] oldest_age_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  arbs_cmd_t        cmd_q, cmd_d;
  logic [63:0]      now_q;
  logic [31:0]      max_age_q;
  logic             busy_q;
  logic [CNT_W-1:0] step_q;
  logic             done_q;
  arbs_scan_t       res_q;
  arbs_scan_t       chain [ENTRIES+1];
  arbs_scan_t       seed;
  logic [ENTRIES-1:0] act;
  logic             acc;

  assign acc    = start && !busy_q;
  assign busy_o = busy_q;

  always_comb begin
    cmd_d          = '0;
    cmd_d.action   = action_i;
    cmd_d.idx      = entry_index_i;
    cmd_d.status   = entry_status_i;
    cmd_d.now      = now_q;
    cmd_d.limit    = (now_q > MAX_AGE) ? now_q - MAX_AGE : 64'd0;
    cmd_d.ready_at = now_q + {48'd0, stall_time_i};
    cmd_d.addr     = req_address_i;
    cmd_d.ans      = answer_flag_i;
    cmd_d.set_hit  = ({28'd0, entry_index_i} < 32'(ENTRIES));
  end

  always_comb begin
    seed         = '0;
    seed.age_ok  = 1'b1;
    seed.max_age = max_age_q;
  end
  assign chain[0] = seed;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign act[g] = busy_q && (step_q == CNT_W'(g));
    arbs_cell #(.IDX_W(IDX_W)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .act_i     (act[g]),
      .my_idx_i  (IDX_W'(g)),
      .set_sel_i (cmd_q.set_hit && (32'(cmd_q.idx) == 32'(g))),
      .cmd_i     (cmd_q),
      .scan_i    (chain[g]),
      .scan_o    (chain[g+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      step_q    <= '0;
      done_q    <= 1'b0;
      now_q     <= '0;
      max_age_q <= '0;
      res_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (acc) begin
        busy_q <= 1'b1;
        step_q <= '0;
        if (action_i == ACT_TICK) begin
          now_q <= now_q + 64'd1;
        end
      end else if (busy_q) begin
        if (step_q == CNT_W'(ENTRIES)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_q  <= chain[ENTRIES];
          if (cmd_q.action == ACT_AGE) begin
            max_age_q <= chain[ENTRIES].max_age;
          end
        end else begin
          step_q <= step_q + CNT_W'(1);
        end
      end
    end
  end

  logic is_set, is_old, is_age;
  assign is_set = cmd_q.action == ACT_SET;
  assign is_old = cmd_q.action == ACT_OLDEST;
  assign is_age = cmd_q.action == ACT_AGE;

  assign done_o            = done_q;
  assign found_o           = is_set ? cmd_q.set_hit : res_q.found;
  assign position_o        = is_set ? (cmd_q.set_hit ? cmd_q.idx : 4'd0)
                                    : res_q.pos[3:0];
  assign found_answer_o    = is_old && res_q.found_ans;
  assign answer_position_o = is_old ? res_q.ans_pos[3:0] : 4'd0;
  assign age_ok_o          = is_age && res_q.age_ok;
  assign oldest_age_o      = max_age_q;

endmodule

/* sv/arbs_checker.sv */
// ----------------------------------------------------------------------------
// arbs_checker
// Port-level checks of the aged request buffer.
// ----------------------------------------------------------------------------
module arbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy_o,
  input logic        done_o,
  input logic        found_o,
  input logic        found_answer_o,
  input logic [3:0]  position_o,
  input logic [3:0]  answer_position_o,
  input logic [31:0] oldest_age_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy_o |=> busy_o) else $error("busy not raised");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("done while busy");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("done without request");
  a_ans_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_answer_o |-> answer_position_o == 4'd0) else $error("answer pos");
  a_age_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |=> oldest_age_o == $past(oldest_age_o) || done_o || busy_o)
    else $error("age moved");

endmodule

bind aged_request_buffer_select arbs_checker u_arbs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy_o(busy_o), .done_o(done_o),
  .found_o(found_o), .found_answer_o(found_answer_o), .position_o(position_o),
  .answer_position_o(answer_position_o), .oldest_age_o(oldest_age_o)
);

/* tb/tb_aged_request_buffer_select.sv */
// ----------------------------------------------------------------------------
// tb_aged_request_buffer_select
// Self-checking testbench for the aged request buffer.
//
// A short directed table runs first: the age check after reset, field
// extremes, every action, freeing an entry, odd status codes and the unused
// action codes. About 1850 random requests follow. An internal model of the
// table predicts the untyped results, and all are checked in order, field
// by field. MAX_AGE is set small so that the age limit is crossed within the
// run. The sender works in random bursts and gaps. There is no result-side
// stall, since the result is a one-cycle strobe.
// ----------------------------------------------------------------------------
module tb_aged_request_buffer_select;
  import arbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned     NSLOT     = 16;
  localparam longint unsigned AGE_LIMIT = 64'd512;
  localparam int              N_RANDOM  = 1850;
  localparam int              WD_LIMIT  = 2000;
  localparam int              N_PLAN    = 16;

  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  localparam logic [2:0] ST_UNTREATED = 3'd1;
  localparam logic [2:0] ST_WAIT      = 3'd2;
  localparam logic [2:0] ST_READY     = 3'd3;
  localparam logic [2:0] ST_TRANSMIT  = 3'd4;
  localparam logic [2:0] ST_ODD       = 3'd7;

  typedef struct packed {
    logic        found;
    logic [3:0]  pos;
    logic        found_ans;
    logic [3:0]  ans_pos;
    logic        age_ok;
    logic [31:0] oldest;
  } outcome_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  idx;
    logic [2:0]  status;
    logic [15:0] stall;
    logic [63:0] addr;
    logic        ans;
  } request_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    outcome_t want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy_o;
  logic [2:0]  action_i = '0;
  logic [3:0]  entry_index_i = '0;
  logic [2:0]  entry_status_i = '0;
  logic [15:0] stall_time_i = '0;
  logic [63:0] req_address_i = '0;
  logic        answer_flag_i = 1'b0;
  logic        done_o;
  logic        found_o;
  logic [3:0]  position_o;
  logic        found_answer_o;
  logic [3:0]  answer_position_o;
  logic        age_ok_o;
  logic [31:0] oldest_age_o;

  always #6 clk_i = ~clk_i;

  aged_request_buffer_select #(
    .ENTRIES(NSLOT),
    .MAX_AGE(AGE_LIMIT)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy_o(busy_o),
    .action_i(action_i),
    .entry_index_i(entry_index_i),
    .entry_status_i(entry_status_i),
    .stall_time_i(stall_time_i),
    .req_address_i(req_address_i),
    .answer_flag_i(answer_flag_i),
    .done_o(done_o),
    .found_o(found_o),
    .position_o(position_o),
    .found_answer_o(found_answer_o),
    .answer_position_o(answer_position_o),
    .age_ok_o(age_ok_o),
    .oldest_age_o(oldest_age_o)
  );

  // Table model
  logic [2:0]  tbl_status  [NSLOT];
  logic [63:0] tbl_ready   [NSLOT];
  logic [63:0] tbl_birth   [NSLOT];
  logic [63:0] tbl_addr    [NSLOT];
  logic        tbl_ans     [NSLOT];
  bit          tbl_written [NSLOT];
  logic [63:0] now_cycle;
  logic [31:0] peak_age;

  outcome_t pending_outcomes[$];
  int       n_errors;
  int       idle_cycles = 0;
  logic [63:0] addr_pool[4];

  function automatic bit slot_ready_for(int i, logic [2:0] st);
    return tbl_status[i] == st && tbl_ready[i] <= now_cycle;
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t    o;
    logic [63:0] best_rq;
    logic [63:0] best_an;
    logic [63:0] lim;
    logic [63:0] age;
    bit          stop;
    o = '0;
    best_rq = '0;
    best_an = '0;
    stop = 0;
    case (r.action)
      ACT_TICK: now_cycle = now_cycle + 64'd1;
      ACT_ALLOC: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!stop && tbl_status[i] == ST_FREE) begin
            tbl_status[i] = r.status;
            tbl_ready[i] = now_cycle + 64'(r.stall);
            tbl_birth[i] = now_cycle;
            tbl_addr[i] = r.addr;
            tbl_ans[i] = r.ans;
            tbl_written[i] = 1;
            o.found = 1'b1;
            o.pos = 4'(i);
            stop = 1;
          end
        end
      end
      ACT_SET: begin
        o.found = 1'b1;
        o.pos = r.idx;
        if (r.status == ST_FREE) begin
          tbl_status[r.idx] = ST_FREE;
          tbl_ready[r.idx] = now_cycle;
          tbl_birth[r.idx] = now_cycle;
          tbl_addr[r.idx] = '0;
          tbl_ans[r.idx] = 1'b0;
          tbl_written[r.idx] = 1;
        end else begin
          tbl_status[r.idx] = r.status;
          tbl_ready[r.idx] = now_cycle + 64'(r.stall);
        end
      end
      ACT_OLDEST: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_ready_for(i, r.status)) begin
            if (tbl_ans[i]) begin
              if (!o.found_ans || tbl_birth[i] < best_an) begin
                o.found_ans = 1'b1;
                o.ans_pos = 4'(i);
                best_an = tbl_birth[i];
              end
            end else if (!o.found || tbl_birth[i] < best_rq) begin
              o.found = 1'b1;
              o.pos = 4'(i);
              best_rq = tbl_birth[i];
            end
          end
        end
      end
      ACT_ADDR: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!stop && slot_ready_for(i, r.status) && tbl_addr[i] == r.addr) begin
            o.found = 1'b1;
            o.pos = 4'(i);
            stop = 1;
          end
        end
      end
      ACT_AGE: begin
        lim = (now_cycle > AGE_LIMIT) ? now_cycle - AGE_LIMIT : '0;
        o.age_ok = 1'b1;
        for (int i = 0; i < NSLOT; i++) begin
          if (!stop && tbl_status[i] != ST_FREE) begin
            if (tbl_birth[i] < lim) begin
              o.age_ok = 1'b0;
              stop = 1;
            end else begin
              age = now_cycle - tbl_birth[i];
              if (age > 64'(peak_age))
                peak_age = (age > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : age[31:0];
            end
          end
        end
      end
      default: ;
    endcase
    o.oldest = peak_age;
    return o;
  endfunction

  // Keep reads away from entries that were never written.
  function automatic request_t make_legal(request_t r);
    bit all_written;
    all_written = 1;
    for (int i = 0; i < NSLOT; i++) if (!tbl_written[i]) all_written = 0;
    if (r.action == ACT_SET && r.status != ST_FREE && !tbl_written[r.idx])
      r.status = ST_FREE;
    if ((r.action == ACT_OLDEST || r.action == ACT_ADDR) && r.status == ST_FREE
        && !all_written)
      r.status = ST_READY;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       k;
    int       j;
    k = $urandom_range(99);
    if (k < 30)      r.action = ACT_TICK;
    else if (k < 50) r.action = ACT_ALLOC;
    else if (k < 65) r.action = ACT_SET;
    else if (k < 80) r.action = ACT_OLDEST;
    else if (k < 90) r.action = ACT_ADDR;
    else if (k < 97) r.action = ACT_AGE;
    else             r.action = (k == 97) ? ACT_RSVD6 : ACT_RSVD7;
    r.idx = 4'($urandom_range(15));
    k = $urandom_range(99);
    if (r.action == ACT_SET && k < 35) r.status = ST_FREE;
    else if (k < 90)                   r.status = 3'($urandom_range(4, 1));
    else                               r.status = 3'($urandom_range(7));
    k = $urandom_range(99);
    if (k < 70)      r.stall = 16'($urandom_range(7));
    else if (k < 90) r.stall = 16'($urandom_range(63));
    else             r.stall = 16'($urandom);
    j = $urandom_range(NSLOT - 1);
    k = $urandom_range(99);
    if (r.action == ACT_ADDR && k < 70 && tbl_written[j]) r.addr = tbl_addr[j];
    else if (k < 85) r.addr = addr_pool[$urandom_range(3)];
    else             r.addr = {$urandom, $urandom};
    r.ans = 1'($urandom);
    return make_legal(r);
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Hold the fields and start until the request is taken.
  task automatic issue(request_t r, bit typed, outcome_t want);
    outcome_t o;
    action_i <= r.action;
    entry_index_i <= r.idx;
    entry_status_i <= r.status;
    stall_time_i <= r.stall;
    req_address_i <= r.addr;
    answer_flag_i <= r.ans;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    o = apply_request(r);
    pending_outcomes.push_back(typed ? want : o);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pos %0h", $time,
                 position_o);
        n_errors++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("found", want.found, found_o);
        check_field("position", want.pos, position_o);
        check_field("found_answer", want.found_ans, found_answer_o);
        check_field("answer_position", want.ans_pos, answer_position_o);
        check_field("age_ok", want.age_ok, age_ok_o);
        check_field("oldest_age", want.oldest, oldest_age_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy_o) || done_o) idle_cycles <= 0;
    else                              idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("** aged_request_buffer_select: FAILED **");
      $finish;
    end
  end

  plan_row_t plan[N_PLAN];

  initial begin
    request_t r;
    outcome_t none;
    int       burst;
    n_errors = 0;
    none = '0;
    now_cycle = '0;
    peak_age = '0;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_status[i] = ST_FREE;
      tbl_ready[i] = '0;
      tbl_birth[i] = '0;
      tbl_addr[i] = '0;
      tbl_ans[i] = 1'b0;
      tbl_written[i] = 0;
    end
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = {$urandom, $urandom};
    addr_pool[3] = {$urandom, $urandom};

    //          action      idx  status        stall      addr                 ans typed want
    plan[0]  = '{'{ACT_AGE,    0, ST_FREE,      16'd0,     64'd0,               0}, 1,
                 '{0, 0, 0, 0, 1, 32'd0}};
    plan[1]  = '{'{ACT_ALLOC,  0, ST_READY,     16'd0,     '1,                  0}, 1,
                 '{1, 0, 0, 0, 0, 32'd0}};
    plan[2]  = '{'{ACT_ALLOC, 15, ST_READY,     16'hFFFF,  64'd0,               1}, 1,
                 '{1, 1, 0, 0, 0, 32'd0}};
    plan[3]  = '{'{ACT_ALLOC,  0, ST_TRANSMIT,  16'd0,     64'h5555_AAAA_5555_AAAA, 1}, 1,
                 '{1, 2, 0, 0, 0, 32'd0}};
    plan[4]  = '{'{ACT_ALLOC,  0, ST_READY,     16'd1,     64'hAAAA_5555_AAAA_5555, 1}, 0,
                 none};
    plan[5]  = '{'{ACT_TICK,   0, ST_FREE,      16'd0,     64'd0,               0}, 0, none};
    plan[6]  = '{'{ACT_OLDEST, 0, ST_READY,     16'd0,     64'd0,               0}, 0, none};
    plan[7]  = '{'{ACT_ADDR,   0, ST_READY,     16'd0,     '1,                  0}, 0, none};
    plan[8]  = '{'{ACT_SET,    1, ST_READY,     16'd0,     64'd0,               0}, 0, none};
    plan[9]  = '{'{ACT_OLDEST, 0, ST_READY,     16'd0,     64'd0,               0}, 0, none};
    plan[10] = '{'{ACT_SET,   15, ST_FREE,      16'hFFFF,  '1,                  1}, 1,
                 '{1, 15, 0, 0, 0, 32'd0}};
    plan[11] = '{'{ACT_SET,    2, ST_ODD,       16'd1,     64'd0,               0}, 0, none};
    plan[12] = '{'{ACT_RSVD6,  7, ST_READY,     16'd3,     '1,                  1}, 1, none};
    plan[13] = '{'{ACT_RSVD7,  7, ST_WAIT,      16'd3,     '1,                  1}, 1, none};
    plan[14] = '{'{ACT_TICK,   0, ST_FREE,      16'd0,     64'd0,               0}, 0, none};
    plan[15] = '{'{ACT_AGE,    0, ST_FREE,      16'd0,     64'd0,               0}, 0, none};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) issue(make_legal(plan[i].req), plan[i].typed, plan[i].want);
    drain();

    burst = $urandom_range(12);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) drain();
      if (burst == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(20)) @(posedge clk_i);
        burst = (n > N_RANDOM / 2 && n < N_RANDOM / 2 + 100) ? 100 : $urandom_range(1, 12);
      end
      r = random_request();
      issue(r, 0, none);
      burst--;
    end
    drain();
    repeat (40) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("** aged_request_buffer_select: PASSED **");
    end else begin
      $display("** aged_request_buffer_select: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/arbs_pkg.sv
sv/arbs_cell.sv
sv/aged_request_buffer_select.sv
sv/arbs_checker.sv
tb/tb_aged_request_buffer_select.sv
